/* design/scpa_pkg.sv */
`default_nettype none
package scpa_pkg;

	localparam int POOL_BYTES  = 65536;
	localparam int ALIGN_BYTES = 16;
	localparam int LIST_DEPTH  = 16;
	localparam int MAX_CLASSES = 24;

	// growth sequence from 4, next = floor(cur * 1.618), fixed for any capacity
	localparam int GROWTH_N = 22;
	localparam logic [16:0] GROWTH_RAW [GROWTH_N] = '{
		17'd4, 17'd6, 17'd9, 17'd14, 17'd22, 17'd35, 17'd56, 17'd90, 17'd145,
		17'd234, 17'd378, 17'd611, 17'd988, 17'd1598, 17'd2585, 17'd4182,
		17'd6766, 17'd10947, 17'd17712, 17'd28658, 17'd46368, 17'd75023
	};
	// same sequence rounded up to ALIGN_BYTES
	localparam logic [16:0] GROWTH_ALIGNED [GROWTH_N] = '{
		17'd16, 17'd16, 17'd16, 17'd16, 17'd32, 17'd48, 17'd64, 17'd96, 17'd160,
		17'd240, 17'd384, 17'd624, 17'd992, 17'd1600, 17'd2592, 17'd4192,
		17'd6768, 17'd10960, 17'd17712, 17'd28672, 17'd46368, 17'd75024
	};

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ZERO    = 2'd1;
	localparam logic [1:0] ST_NO_ROOM = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [16:0] req_size;
		logic [15:0] block_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted_offset;
		logic [16:0] used_bytes;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic classify;
		logic exec;
		logic respond;
	} cmd_t;

endpackage
`default_nettype wire

/* design/scpa_ctrl.sv */
`default_nettype none
module scpa_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	output scpa_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CLASS = 4'b0010,
		S_EXEC  = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_nx = S_CLASS;
			S_CLASS: state_nx = S_EXEC;
			S_EXEC:  state_nx = S_RESP;
			S_RESP:  state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	assign busy         = (state_q != S_IDLE);
	assign cmd.load     = (state_q == S_IDLE) && start;
	assign cmd.classify = (state_q == S_CLASS);
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.respond  = (state_q == S_RESP);

endmodule
`default_nettype wire

/* design/scpa_datapath.sv */
`default_nettype none
module scpa_datapath #(
	parameter int LIST_DEPTH  = scpa_pkg::LIST_DEPTH,
	parameter int MAX_CLASSES = scpa_pkg::MAX_CLASSES
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire scpa_pkg::cmd_t  cmd,
	input  wire scpa_pkg::req_t  req,
	input  wire                  cfg_we,
	input  wire [16:0]           cfg_wdata,
	output logic                 done,
	output scpa_pkg::rsp_t       result
);

	localparam int CLS_W  = $clog2(MAX_CLASSES);
	localparam int FILL_W = $clog2(LIST_DEPTH + 1);
	localparam int DEPTH  = MAX_CLASSES * LIST_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int NG     = (scpa_pkg::GROWTH_N < MAX_CLASSES - 1) ?
	                        scpa_pkg::GROWTH_N : MAX_CLASSES - 1;

	logic [16:0] cap_q, used_q, bump_q, sz_q;
	logic [CLS_W-1:0] cls_q;
	logic [FILL_W-1:0] fill_q [MAX_CLASSES];
	scpa_pkg::req_t req_q;
	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q, gbump_q;
	logic gsel_q, done_q;
	logic [1:0] status_q;

	// index of the capacity class = number of growth entries that fit
	logic [CLS_W-1:0] last_cls;
	always_comb begin
		last_cls = '0;
		for (int i = 0; i < NG; i++)
			if (scpa_pkg::GROWTH_RAW[i] <= cap_q) last_cls = CLS_W'(i + 1);
	end

	logic [17:0] aligned;
	logic [CLS_W-1:0] cls_d;
	logic [16:0] sz_d;
	always_comb begin
		aligned = ({1'b0, req_q.req_size} + 18'(scpa_pkg::ALIGN_BYTES - 1))
		          & ~18'(scpa_pkg::ALIGN_BYTES - 1);
		cls_d = last_cls;
		for (int i = NG - 1; i >= 1; i--)
			if (CLS_W'(i) < last_cls && aligned <= {1'b0, scpa_pkg::GROWTH_ALIGNED[i]})
				cls_d = CLS_W'(i);
		sz_d = cap_q;
		for (int i = 0; i < NG; i++)
			if (CLS_W'(i) == cls_d && CLS_W'(i) < last_cls)
				sz_d = scpa_pkg::GROWTH_ALIGNED[i];
	end

	// capacity write: round up, clamp to ALIGN..POOL
	logic [17:0] cap_rnd;
	logic [16:0] cap_d;
	always_comb begin
		cap_rnd = ({1'b0, cfg_wdata} + 18'(scpa_pkg::ALIGN_BYTES - 1))
		          & ~18'(scpa_pkg::ALIGN_BYTES - 1);
		if (cap_rnd < 18'(scpa_pkg::ALIGN_BYTES)) cap_d = 17'(scpa_pkg::ALIGN_BYTES);
		else if (cap_rnd > 18'(scpa_pkg::POOL_BYTES)) cap_d = 17'(scpa_pkg::POOL_BYTES);
		else cap_d = cap_rnd[16:0];
	end

	logic [FILL_W-1:0] fill_cur;
	logic [17:0] used_sum, bump_sum;
	logic [ADDR_W-1:0] base, addr;
	logic mem_rd, mem_wr, fill_dec, fill_inc, bump_adv, used_add, used_sub, clear;
	logic [1:0] status_d;
	always_comb begin
		fill_cur = fill_q[cls_q];
		used_sum = {1'b0, used_q} + {1'b0, sz_q};
		bump_sum = {1'b0, bump_q} + {1'b0, sz_q};
		base     = ADDR_W'(cls_q) * ADDR_W'(LIST_DEPTH);
		addr     = base + ADDR_W'(fill_cur);
		mem_rd = 1'b0; mem_wr = 1'b0; fill_dec = 1'b0; fill_inc = 1'b0;
		bump_adv = 1'b0; used_add = 1'b0; used_sub = 1'b0; clear = 1'b0;
		status_d = scpa_pkg::ST_OK;
		case (req_q.req_type)
			scpa_pkg::REQ_ALLOC: begin
				if (req_q.req_size == '0) status_d = scpa_pkg::ST_ZERO;
				else if (used_sum > {1'b0, cap_q}) status_d = scpa_pkg::ST_NO_ROOM;
				else if (fill_cur != '0) begin
					addr = base + ADDR_W'(fill_cur - FILL_W'(1));
					mem_rd = 1'b1; fill_dec = 1'b1; used_add = 1'b1;
				end else if (bump_sum > {1'b0, cap_q}) status_d = scpa_pkg::ST_NO_ROOM;
				else begin
					bump_adv = 1'b1; used_add = 1'b1;
				end
			end
			scpa_pkg::REQ_FREE: begin
				if (req_q.req_size == '0) status_d = scpa_pkg::ST_ZERO;
				else if (fill_cur >= FILL_W'(LIST_DEPTH)) status_d = scpa_pkg::ST_FULL;
				else begin
					mem_wr = 1'b1; fill_inc = 1'b1; used_sub = 1'b1;
				end
			end
			scpa_pkg::REQ_CLEAR: clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && mem_wr) mem[addr] <= req_q.block_offset;
		if (cmd.exec && mem_rd) rdata_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.classify) begin
			cls_q <= cls_d;
			sz_q  <= sz_d;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			gsel_q   <= mem_rd;
			gbump_q  <= bump_adv ? bump_q[15:0] : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= 17'(scpa_pkg::POOL_BYTES);
			used_q <= '0;
			bump_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < MAX_CLASSES; i++) fill_q[i] <= '0;
		end else begin
			done_q <= cmd.exec;
			if (cfg_we || (cmd.exec && clear)) begin
				used_q <= '0;
				bump_q <= '0;
				for (int i = 0; i < MAX_CLASSES; i++) fill_q[i] <= '0;
				if (cfg_we) cap_q <= cap_d;
			end else if (cmd.exec) begin
				if (used_add) used_q <= used_sum[16:0];
				if (used_sub) used_q <= (used_q >= sz_q) ? used_q - sz_q : 17'd0;
				if (bump_adv) bump_q <= bump_sum[16:0];
				if (fill_dec) fill_q[cls_q] <= fill_cur - FILL_W'(1);
				if (fill_inc) fill_q[cls_q] <= fill_cur + FILL_W'(1);
			end
		end
	end

	assign done                  = done_q && cmd.respond;
	assign result.status         = status_q;
	assign result.granted_offset = gsel_q ? rdata_q : gbump_q;
	assign result.used_bytes     = used_q;

endmodule
`default_nettype wire

/* design/size_class_pool_allocator.sv */
`default_nettype none
// A request is taken when start is high and busy low; its result strobes on done
// in the respond state, after the classify and execute (free-list access) states.
// A new request is taken only once the controller is back in idle after the four
// states (idle, classify, execute, respond). Results cannot be stalled by the receiver.
// Reset: capacity returns to the full pool, all free lists and counters empty.
module size_class_pool_allocator #(
	parameter int LIST_DEPTH  = scpa_pkg::LIST_DEPTH,
	parameter int MAX_CLASSES = scpa_pkg::MAX_CLASSES
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire scpa_pkg::req_t  req,
	input  wire                  cfg_we,
	input  wire [16:0]           cfg_wdata,
	output logic                 done,
	output scpa_pkg::rsp_t       result
);

	scpa_pkg::cmd_t cmd;

	scpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	scpa_datapath #(
		.LIST_DEPTH  (LIST_DEPTH),
		.MAX_CLASSES (MAX_CLASSES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held more than one cycle");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a transaction");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != scpa_pkg::ST_OK |-> result.granted_offset == 16'd0)
		else $error("nonzero offset on failed request");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.used_bytes <= 17'(scpa_pkg::POOL_BYTES))
		else $error("used bytes beyond pool");

endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
module testbench;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		scpa_pkg::req_t r;
		bit             typed;
		scpa_pkg::rsp_t want;
	} stim_row_t;

	typedef struct {
		logic [15:0] offs;
		logic [16:0] size;
	} live_block_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	scpa_pkg::req_t req;
	logic cfg_we;
	logic [16:0] cfg_wdata;
	logic done;
	scpa_pkg::rsp_t result;

	size_class_pool_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
	);

	always #6 clk = ~clk;

	// allocator image
	int unsigned capacity;
	int unsigned used_total;
	int unsigned bump_offs;
	int unsigned class_lim [scpa_pkg::MAX_CLASSES];
	int unsigned class_cnt;
	logic [15:0] list_mem [scpa_pkg::MAX_CLASSES][scpa_pkg::LIST_DEPTH];
	int unsigned list_fill [scpa_pkg::MAX_CLASSES];

	scpa_pkg::rsp_t pending_rsp [$];
	live_block_t live_blocks [$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_cfg = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	function automatic int unsigned align_up(int unsigned v);
		return ((v + scpa_pkg::ALIGN_BYTES - 1) / scpa_pkg::ALIGN_BYTES) * scpa_pkg::ALIGN_BYTES;
	endfunction

	function automatic void empty_pool();
		foreach (list_fill[i]) list_fill[i] = 0;
		used_total = 0;
		bump_offs = 0;
	endfunction

	function automatic void set_capacity(logic [16:0] value);
		int unsigned v;
		int unsigned cur;
		int unsigned n;
		v = align_up(value);
		if (v < scpa_pkg::ALIGN_BYTES) v = scpa_pkg::ALIGN_BYTES;
		if (v > scpa_pkg::POOL_BYTES) v = scpa_pkg::POOL_BYTES;
		capacity = v;
		cur = 4;
		n = 0;
		while (cur <= capacity && n < scpa_pkg::MAX_CLASSES - 1) begin
			class_lim[n] = align_up(cur);
			n++;
			cur = (cur * 1618) / 1000;
		end
		class_lim[n] = capacity;
		class_cnt = n + 1;
		empty_pool();
	endfunction

	function automatic int unsigned size_class(int unsigned size);
		int unsigned a;
		a = align_up(size);
		for (int unsigned i = 1; i < class_cnt; i++)
			if (a <= class_lim[i]) return i;
		return class_cnt - 1;
	endfunction

	function automatic scpa_pkg::rsp_t serve_request(scpa_pkg::req_t r);
		scpa_pkg::rsp_t o;
		int unsigned c;
		int unsigned sz;
		o = '0;
		if (r.req_type == scpa_pkg::REQ_ALLOC || r.req_type == scpa_pkg::REQ_FREE) begin
			if (r.req_size == 0) begin
				o.status = scpa_pkg::ST_ZERO;
			end else begin
				c = size_class(r.req_size);
				sz = class_lim[c];
				if (r.req_type == scpa_pkg::REQ_ALLOC) begin
					if (used_total + sz > capacity) begin
						o.status = scpa_pkg::ST_NO_ROOM;
					end else if (list_fill[c] > 0) begin
						list_fill[c]--;
						o.granted_offset = list_mem[c][list_fill[c]];
						used_total += sz;
					end else if (bump_offs + sz > capacity) begin
						o.status = scpa_pkg::ST_NO_ROOM;
					end else begin
						o.granted_offset = bump_offs[15:0];
						bump_offs += sz;
						used_total += sz;
					end
				end else if (list_fill[c] >= scpa_pkg::LIST_DEPTH) begin
					o.status = scpa_pkg::ST_FULL;
				end else begin
					list_mem[c][list_fill[c]] = r.block_offset;
					list_fill[c]++;
					used_total = (used_total >= sz) ? used_total - sz : 0;
				end
			end
		end else if (r.req_type == scpa_pkg::REQ_CLEAR) begin
			empty_pool();
		end
		o.used_bytes = used_total[16:0];
		return o;
	endfunction

	function automatic scpa_pkg::req_t mk(logic [1:0] t, logic [16:0] s, logic [15:0] o);
		scpa_pkg::req_t r;
		r.req_type = t;
		r.req_size = s;
		r.block_offset = o;
		return r;
	endfunction

	function automatic scpa_pkg::rsp_t rs(logic [1:0] s, logic [15:0] g, logic [16:0] u);
		scpa_pkg::rsp_t x;
		x.status = s;
		x.granted_offset = g;
		x.used_bytes = u;
		return x;
	endfunction

	// one transaction; start stays high across back-to-back requests
	task automatic issue(scpa_pkg::req_t r, bit typed = 1'b0, scpa_pkg::rsp_t want = '0);
		scpa_pkg::rsp_t p;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		p = serve_request(r);
		if (r.req_type == scpa_pkg::REQ_ALLOC && p.status == scpa_pkg::ST_OK)
			live_blocks.push_back('{p.granted_offset, r.req_size});
		if (r.req_type == scpa_pkg::REQ_CLEAR) live_blocks.delete();
		pending_rsp.push_back(typed ? want : p);
		n_sent++;
	endtask

	task automatic write_capacity(logic [16:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_capacity(v);
		live_blocks.delete();
		n_cfg++;
	endtask

	function automatic scpa_pkg::req_t random_request();
		int unsigned k;
		int unsigned lim;
		int unsigned j;
		live_block_t b;
		k = $urandom_range(99);
		lim = (capacity < 2048) ? capacity : 2048;
		if (k >= 45 && k < 85 && live_blocks.size() != 0) begin
			j = $urandom_range(live_blocks.size() - 1);
			b = live_blocks[j];
			live_blocks.delete(j);
			return mk(scpa_pkg::REQ_FREE, b.size, b.offs);
		end
		if (k < 85) begin
			k = $urandom_range(99);
			if (k < 70)
				return mk(scpa_pkg::REQ_ALLOC, 17'($urandom_range(lim, 1)), 16'($urandom));
			if (k < 95)
				return mk(scpa_pkg::REQ_ALLOC, 17'($urandom_range(capacity, 1)),
					16'($urandom));
			return mk(scpa_pkg::REQ_ALLOC, 17'($urandom_range(131071, 0)), 16'($urandom));
		end
		if (k < 90)
			return mk(scpa_pkg::REQ_FREE, 17'($urandom_range(131071, 1)), 16'($urandom));
		if (k < 94) return mk(2'($urandom_range(1, 0)), 17'd0, 16'($urandom));
		if (k < 97) return mk(scpa_pkg::REQ_CLEAR, 17'($urandom), 16'($urandom));
		return mk(REQ_NONE, 17'($urandom), 16'($urandom));
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			scpa_pkg::rsp_t e;
			if (pending_rsp.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				n_checked++;
				if (result.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, result.status);
					errors++;
				end
				if (result.granted_offset !== e.granted_offset) begin
					$error("granted_offset: expected %0h, got %0h",
						e.granted_offset, result.granted_offset);
					errors++;
				end
				if (result.used_bytes !== e.used_bytes) begin
					$error("used_bytes: expected %0d, got %0d",
						e.used_bytes, result.used_bytes);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	stim_row_t rows [] = '{
		'{mk(scpa_pkg::REQ_ALLOC, 17'd0, 16'hFFFF),    1,
			rs(scpa_pkg::ST_ZERO, 16'd0, 17'd0)},
		'{mk(scpa_pkg::REQ_FREE, 17'd0, 16'h1234),     1,
			rs(scpa_pkg::ST_ZERO, 16'd0, 17'd0)},
		'{mk(scpa_pkg::REQ_ALLOC, 17'd1, 16'd0),       1,
			rs(scpa_pkg::ST_OK, 16'd0, 17'd16)},
		'{mk(scpa_pkg::REQ_ALLOC, 17'd65536, 16'd0),   1,
			rs(scpa_pkg::ST_NO_ROOM, 16'd0, 17'd16)},
		'{mk(REQ_NONE, 17'h1FFFF, 16'hFFFF),           1,
			rs(scpa_pkg::ST_OK, 16'd0, 17'd16)},
		'{mk(scpa_pkg::REQ_CLEAR, 17'd0, 16'd0),       1,
			rs(scpa_pkg::ST_OK, 16'd0, 17'd0)},
		'{mk(scpa_pkg::REQ_ALLOC, 17'd65536, 16'd0),   1,
			rs(scpa_pkg::ST_OK, 16'd0, 17'd65536)},
		'{mk(scpa_pkg::REQ_ALLOC, 17'd1, 16'd0),       1,
			rs(scpa_pkg::ST_NO_ROOM, 16'd0, 17'd65536)},
		'{mk(scpa_pkg::REQ_FREE, 17'd65536, 16'd0),    1,
			rs(scpa_pkg::ST_OK, 16'd0, 17'd0)},
		'{mk(scpa_pkg::REQ_FREE, 17'h1FFFF, 16'h8000), 1,
			rs(scpa_pkg::ST_OK, 16'd0, 17'd0)},
		'{mk(scpa_pkg::REQ_ALLOC, 17'h1FFFF, 16'd0),   0, '0},
		'{mk(scpa_pkg::REQ_ALLOC, 17'd100, 16'd0),     0, '0}
	};

	int unsigned cap_plan [] = '{65536, 16, 0, 131071, 1000, 256, 0};

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		set_capacity(17'd65536);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 15;
		foreach (rows[i]) issue(rows[i].r, rows[i].typed, rows[i].want);
		// fill the smallest class list past its depth, then pop the top entry
		for (int i = 0; i <= scpa_pkg::LIST_DEPTH; i++)
			issue(mk(scpa_pkg::REQ_FREE, 17'd16, 16'hF000 | i[15:0]));
		issue(mk(scpa_pkg::REQ_ALLOC, 17'd3, 16'd0));

		foreach (cap_plan[p]) begin
			idle_pct = (p < 2) ? 15 : (p < 5) ? 84 : 0;
			write_capacity((p == 6) ? 17'($urandom_range(65536, 16)) : 17'(cap_plan[p]));
			for (int i = 0; i < 107; i++) issue(random_request());
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d transactions, %0d results checked, %0d capacity settings",
			n_sent, n_checked, n_cfg + 1);
		$display("sender idle at 15%%, 84%% and 0%%; zero size, no room, list full, clear");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
design/scpa_pkg.sv
design/scpa_ctrl.sv
design/scpa_datapath.sv
design/size_class_pool_allocator.sv
sim/testbench.sv
